// ===== sv/posam_pkg.sv =====
// ----------------------------------------------------------------------------
// posam_pkg
// Constants, stage types and helpers for the posit add/multiply pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package posam_pkg;

  localparam int POSIT_WIDTH = 32;
  localparam int WORD_W      = 64;
  localparam int SIG_W       = POSIT_WIDTH - 4;
  localparam int FRAC_W      = SIG_W - 1;
  localparam int PROD_W      = 2 * SIG_W;
  localparam int SCALE_W     = 10;
  localparam int KMAX        = POSIT_WIDTH - 3;
  localparam int KMIN        = -(POSIT_WIDTH - 2);

  localparam logic [POSIT_WIDTH-1:0] NAR    = {1'b1, {(POSIT_WIDTH-1){1'b0}}};
  localparam logic [POSIT_WIDTH-1:0] ZERO   = '0;
  localparam logic [POSIT_WIDTH-2:0] MAXPOS = '1;
  localparam logic [POSIT_WIDTH-2:0] MINPOS = {{(POSIT_WIDTH-2){1'b0}}, 1'b1};

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } op_t;

  // after decode
  typedef struct packed {
    op_t                     op;
    logic                    spec;
    logic [POSIT_WIDTH-1:0]  spec_val;
    logic                    na;
    logic                    nb;
    logic signed [SCALE_W-1:0] sa;
    logic signed [SCALE_W-1:0] sb;
    logic [SIG_W-1:0]        ma;
    logic [SIG_W-1:0]        mb;
  } dec_t;

  // after alignment / product
  typedef struct packed {
    op_t                     op;
    logic                    spec;
    logic [POSIT_WIDTH-1:0]  spec_val;
    logic                    na;
    logic                    nb;
    logic signed [SCALE_W-1:0] scale;
    logic [WORD_W-1:0]       big;
    logic [WORD_W-1:0]       sh;
    logic                    flag;
    logic [PROD_W-1:0]       prod;
  } aln_t;

  // unnormalised magnitude, also used after normalising
  typedef struct packed {
    logic                    spec;
    logic [POSIT_WIDTH-1:0]  spec_val;
    logic                    neg;
    logic signed [SCALE_W-1:0] scale;
    logic [WORD_W-1:0]       sig;
    logic                    sticky;
  } mag_t;

  // posit bit string before rounding
  typedef struct packed {
    logic                    spec;
    logic [POSIT_WIDTH-1:0]  spec_val;
    logic                    neg;
    logic                    sat_hi;
    logic                    sat_lo;
    logic [POSIT_WIDTH-2:0]  body;
    logic                    guard;
    logic                    sticky;
  } enc_t;

  // leading zero count over a 64-bit word, 64 for zero
  function automatic logic [6:0] lzc64(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    logic [6:0]        n;
    t = x;
    n = '0;
    for (int i = 5; i >= 0; i--) begin
      if ((t >> (WORD_W - (1 << i))) == '0) begin
        n = n | (7'd1 << i);
        t = t << (1 << i);
      end
    end
    if (!t[WORD_W-1]) begin
      n = n + 7'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/posit_add_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// posit_add_multiply_unit
// 32-bit posit (es = 2) adder and multiplier, six register stages.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, operation, operand_a, | in
//          | operand_b                                 |
//  out     | out_valid, out_ready, result              | out
//
//  one beat per cycle while the output is not held; each beat passes every stage register in turn
//  stages: decode, align or multiply, add, normalise, regime build, round
//  the whole pipe advances together; a held output beat freezes every stage
//  and drops in_ready, bubbles fill when the output is empty
//  rst clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module posit_add_multiply_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result
);

  localparam int N  = posam_pkg::POSIT_WIDTH;
  localparam int W  = posam_pkg::WORD_W;
  localparam int SW = posam_pkg::SCALE_W;

  localparam logic [N-1:0] ZERO_F = '0;

  logic en;
  logic v1, v2, v3, v4, v5;
  posam_pkg::dec_t s1, s1_next;
  posam_pkg::aln_t s2, s2_next;
  posam_pkg::mag_t s3, s3_next;
  posam_pkg::mag_t s4, s4_next;
  posam_pkg::enc_t s5, s5_next;
  logic [N-1:0]    result_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- decode ----------------
  logic [N-1:0]   a, b, pa, pb;
  logic           na, nb;
  logic [N-2:0]   ba, bb, ia, ib;
  logic [6:0]     m_a, m_b;
  logic [W-1:0]   ya, yb;
  logic signed [SW-1:0] ka, kb;

  always_comb begin
    a  = operand_a[N-1:0];
    b  = operand_b[N-1:0];
    na = a[N-1];
    nb = b[N-1];
    pa = na ? (ZERO_F - a) : a;
    pb = nb ? (ZERO_F - b) : b;
    ba = pa[N-2:0];
    bb = pb[N-2:0];
    ia = ba[N-2] ? ~ba : ba;
    ib = bb[N-2] ? ~bb : bb;
    m_a = posam_pkg::lzc64({ia, 1'b1, {(W-N){1'b0}}});
    m_b = posam_pkg::lzc64({ib, 1'b1, {(W-N){1'b0}}});
    ka = ba[N-2] ? ($signed({3'b000, m_a}) - SW'(1)) : -$signed({3'b000, m_a});
    kb = bb[N-2] ? ($signed({3'b000, m_b}) - SW'(1)) : -$signed({3'b000, m_b});
    ya = {ba, {(W-N+1){1'b0}}} << (m_a + 7'd1);
    yb = {bb, {(W-N+1){1'b0}}} << (m_b + 7'd1);

    s1_next.op = posam_pkg::op_t'(operation);
    s1_next.na = na;
    s1_next.nb = nb;
    s1_next.sa = (ka <<< 2) + $signed({{(SW-2){1'b0}}, ya[W-1:W-2]});
    s1_next.sb = (kb <<< 2) + $signed({{(SW-2){1'b0}}, yb[W-1:W-2]});
    s1_next.ma = {1'b1, ya[W-3 -: posam_pkg::FRAC_W]};
    s1_next.mb = {1'b1, yb[W-3 -: posam_pkg::FRAC_W]};
    s1_next.spec     = 1'b0;
    s1_next.spec_val = posam_pkg::ZERO;
    if (a == posam_pkg::NAR || b == posam_pkg::NAR) begin
      s1_next.spec     = 1'b1;
      s1_next.spec_val = posam_pkg::NAR;
    end else if (operation == posam_pkg::OP_MUL) begin
      if (a == posam_pkg::ZERO || b == posam_pkg::ZERO) begin
        s1_next.spec = 1'b1;
      end
    end else if (a == posam_pkg::ZERO) begin
      s1_next.spec     = 1'b1;
      s1_next.spec_val = b;
    end else if (b == posam_pkg::ZERO) begin
      s1_next.spec     = 1'b1;
      s1_next.spec_val = a;
    end
  end

  // ---------------- align or multiply ----------------
  logic                 swp;
  logic signed [SW-1:0] d;
  logic [W-1:0]         mb64;

  always_comb begin
    swp  = s1.sa < s1.sb;
    d    = swp ? (s1.sb - s1.sa) : (s1.sa - s1.sb);
    mb64 = {1'b0, (swp ? s1.ma : s1.mb), {(W-posam_pkg::SIG_W-1){1'b0}}};
    s2_next.op       = s1.op;
    s2_next.spec     = s1.spec;
    s2_next.spec_val = s1.spec_val;
    s2_next.prod     = s1.ma * s1.mb;
    s2_next.big      = {1'b0, (swp ? s1.mb : s1.ma), {(W-posam_pkg::SIG_W-1){1'b0}}};
    if (s1.op == posam_pkg::OP_MUL) begin
      s2_next.na    = s1.na ^ s1.nb;
      s2_next.nb    = 1'b0;
      s2_next.scale = s1.sa + s1.sb + SW'(1);
    end else begin
      s2_next.na    = swp ? s1.nb : s1.na;
      s2_next.nb    = swp ? s1.na : s1.nb;
      s2_next.scale = (swp ? s1.sb : s1.sa) + SW'(1);
    end
    if (d[SW-1:6] != '0) begin
      s2_next.sh   = '0;
      s2_next.flag = 1'b1;
    end else begin
      s2_next.sh   = mb64 >> d[5:0];
      s2_next.flag = ((s2_next.sh << d[5:0]) != mb64);
    end
  end

  // ---------------- add / subtract ----------------
  always_comb begin
    s3_next.spec     = s2.spec;
    s3_next.spec_val = s2.spec_val;
    s3_next.scale    = s2.scale;
    s3_next.neg      = s2.na;
    if (s2.op == posam_pkg::OP_MUL) begin
      s3_next.sig    = {s2.prod, {(W-posam_pkg::PROD_W){1'b0}}};
      s3_next.sticky = 1'b0;
    end else begin
      s3_next.sticky = s2.flag;
      if (s2.na == s2.nb) begin
        s3_next.sig = s2.big + s2.sh;
      end else if (s2.flag) begin
        s3_next.sig = s2.big - s2.sh - W'(1);
      end else if (s2.big >= s2.sh) begin
        s3_next.sig = s2.big - s2.sh;
      end else begin
        s3_next.sig = s2.sh - s2.big;
        s3_next.neg = s2.nb;
      end
      // exact cancellation
      if (s3_next.sig == '0 && !s2.flag && !s2.spec) begin
        s3_next.spec     = 1'b1;
        s3_next.spec_val = posam_pkg::ZERO;
      end
    end
  end

  // ---------------- normalise ----------------
  logic [6:0] lz;

  always_comb begin
    lz      = posam_pkg::lzc64(s3.sig);
    s4_next = s3;
    s4_next.sig   = s3.sig << lz[5:0];
    s4_next.scale = s3.scale - $signed({3'b000, lz});
  end

  // ---------------- regime build ----------------
  logic signed [SW-1:0] k;
  logic [1:0]           e;
  logic [4:0]           rl;
  logic [W-1:0]         regm, f, rest, str;

  always_comb begin
    k    = s4.scale >>> 2;
    e    = s4.scale[1:0];
    rl   = (k >= 0) ? 5'(k + SW'(2)) : 5'(SW'(1) - k);
    regm = (k >= 0) ? ({W{1'b1}} << (7'd63 - k[6:0])) : (W'(1) << (7'd63 + k[6:0]));
    f    = s4.sig << 1;
    rest = {e, f[W-1:2]};
    str  = regm | (rest >> rl);
    s5_next.spec     = s4.spec;
    s5_next.spec_val = s4.spec_val;
    s5_next.neg      = s4.neg;
    s5_next.sat_hi   = k > SW'(posam_pkg::KMAX);
    s5_next.sat_lo   = k < SW'(posam_pkg::KMIN);
    s5_next.body     = str[W-1 -: N-1];
    s5_next.guard    = str[W-N];
    s5_next.sticky   = s4.sticky || (f[1:0] != '0) || ((rest << (7'd64 - {2'b00, rl})) != '0)
                       || (str[W-N-1:0] != '0);
  end

  // ---------------- round ----------------
  logic [N-2:0] body;

  always_comb begin
    if (s5.sat_hi) begin
      body = posam_pkg::MAXPOS;
    end else if (s5.sat_lo) begin
      body = posam_pkg::MINPOS;
    end else begin
      body = s5.body + (N-1)'(s5.guard && (s5.sticky || s5.body[0]));
    end
    if (s5.spec) begin
      result_next = s5.spec_val;
    end else if (s5.neg) begin
      result_next = ZERO_F - {1'b0, body};
    end else begin
      result_next = {1'b0, body};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1     <= s1_next;
      s2     <= s2_next;
      s3     <= s3_next;
      s4     <= s4_next;
      s5     <= s5_next;
      result <= 32'(result_next);
    end
  end

  // normalised significand carries its leading one
  a_norm: assert property (@(posedge clk) disable iff (rst)
    v4 && !s4.spec |-> s4.sig[W-1])
    else $error("normalised significand lost its leading one");

  // ordinary results never become NaR
  a_no_nar: assert property (@(posedge clk) disable iff (rst)
    en && v5 && !s5.spec |=> out_valid && result != posam_pkg::NAR)
    else $error("rounded result became NaR");

  // a beat in the last stage reaches the output
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && v5 |=> out_valid)
    else $error("beat dropped before output");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    v5 |-> !(s5.sat_hi && s5.sat_lo))
    else $error("both saturation flags set");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// posit_add_multiply_unit testbench
// Random and directed posit additions and products; each result beat is
// checked in order against a behavioural posit predictor kept in this file.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    posam_pkg::op_t op;
    logic [31:0]    a;
    logic [31:0]    b;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result;

  req_t        pending_ops[$];
  logic [31:0] expected_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          stim_done = 1'b0;
  bit          hold_off = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_phase = 0;

  posit_add_multiply_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .result(result)
  );

  always #6 clk = ~clk;

  function automatic int clz(input logic [63:0] x);
    int n;
    n = 0;
    if (x == 0) return 64;
    while (!x[63]) begin
      x = x << 1;
      n++;
    end
    return n;
  endfunction

  // split a nonzero, non-NaR posit into sign, scale and significand (hidden bit at 63)
  function automatic bit unpack_posit(input logic [31:0] p, output int scale,
                                      output logic [63:0] sig);
    bit          neg;
    logic [63:0] x, y;
    int          m, k;
    neg = p[31];
    if (neg) p = -p;
    x = {32'b0, p} << 33;
    if (x[63]) begin
      m = clz(~x);
      k = m - 1;
    end else begin
      m = clz(x);
      k = -m;
    end
    y = (m + 1 < 64) ? (x << (m + 1)) : 64'd0;
    sig = {1'b1, y[61:0], 1'b0};
    scale = 4 * k + int'(y[63:62]);
    return neg;
  endfunction

  function automatic logic [31:0] pack_posit(input bit neg, input int scale,
                                             input logic [63:0] sig, input bit sticky);
    logic [63:0] body, regime, f, rest, str;
    int          lz, k, e, rl;
    bit          st, guard;
    lz = clz(sig);
    sig = sig << lz;
    scale -= lz;
    k = (scale >= 0) ? scale / 4 : -((-scale + 3) / 4);
    e = scale - 4 * k;
    if (k > posam_pkg::KMAX) begin
      body = 64'h7fff_ffff;
    end else if (k < posam_pkg::KMIN) begin
      body = 64'd1;
    end else begin
      rl = (k >= 0) ? k + 2 : 1 - k;
      regime = (k >= 0) ? ({64{1'b1}} << (63 - k)) : (64'd1 << (63 + k));
      f = sig << 1;
      rest = (64'(e) << 62) | (f >> 2);
      st = sticky || f[1:0] != 0;
      str = regime | (rest >> rl);
      st = st || (rest & ((64'd1 << rl) - 1)) != 0;
      body = str >> 33;
      guard = str[32];
      st = st || str[31:0] != 0;
      if (guard && (st || body[0])) body++;
    end
    if (neg) body = -body;
    return body[31:0];
  endfunction

  function automatic logic [31:0] posit_sum(input logic [31:0] a, input logic [31:0] b);
    int          sa, sb, d, ts;
    logic [63:0] ma, mb, sh, rem, v, tm;
    bit          na, nb, neg, flag;
    if (a == posam_pkg::ZERO) return b;
    if (b == posam_pkg::ZERO) return a;
    na = unpack_posit(a, sa, ma);
    nb = unpack_posit(b, sb, mb);
    if (sa < sb) begin
      ts = sa; sa = sb; sb = ts;
      tm = ma; ma = mb; mb = tm;
      neg = na; na = nb; nb = neg;
    end
    ma >>= 1;
    mb >>= 1;
    d = sa - sb;
    if (d >= 64) begin
      sh = 0; rem = mb;
    end else begin
      sh = mb >> d; rem = mb & ((64'd1 << d) - 1);
    end
    flag = rem != 0;
    neg = na;
    if (na == nb) v = ma + sh;
    else if (flag) v = ma - sh - 1;
    else if (ma >= sh) v = ma - sh;
    else begin
      v = sh - ma;
      neg = nb;
    end
    if (v == 0 && !flag) return posam_pkg::ZERO;
    return pack_posit(neg, sa + 1, v, flag);
  endfunction

  function automatic logic [31:0] posit_product(input logic [31:0] a, input logic [31:0] b);
    int           sa, sb, scale;
    logic [63:0]  ma, mb;
    logic [127:0] p;
    bit           neg;
    if (a == posam_pkg::ZERO || b == posam_pkg::ZERO) return posam_pkg::ZERO;
    neg = unpack_posit(a, sa, ma) != unpack_posit(b, sb, mb);
    p = {64'd0, ma} * {64'd0, mb};
    scale = sa + sb + 1;
    if (!p[127]) begin
      p = p << 1;
      scale--;
    end
    return pack_posit(neg, scale, p[127:64], p[63:0] != 0);
  endfunction

  function automatic logic [31:0] posit_result(input req_t r);
    if (r.a == posam_pkg::NAR || r.b == posam_pkg::NAR) return posam_pkg::NAR;
    return (r.op == posam_pkg::OP_MUL) ? posit_product(r.a, r.b) : posit_sum(r.a, r.b);
  endfunction

  function automatic logic [31:0] random_posit();
    logic [31:0] v;
    int          k;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 15);
      1: v = v >> $urandom_range(0, 31);
      2: v = v | (32'hffff_ffff << $urandom_range(1, 31));
      3: v = {1'b0, 31'h7fff_ffff} - $urandom_range(0, 3);
      4: v = (v & 32'h00ff_ffff) | 32'h4000_0000;
      default: ;
    endcase
    k = $urandom_range(0, 40);
    if (k == 0) v = posam_pkg::NAR;
    else if (k == 1) v = posam_pkg::ZERO;
    else if (k < 5) v = -v;
    return v;
  endfunction

  task automatic queue_op(input posam_pkg::op_t op, input logic [31:0] a,
                          input logic [31:0] b);
    pending_ops.push_back('{op, a, b});
  endtask

  initial begin
    logic [31:0] a;
    queue_op(posam_pkg::OP_ADD, 32'h4000_0000, 32'h4000_0000);
    queue_op(posam_pkg::OP_MUL, 32'h4000_0000, 32'h4800_0000);
    queue_op(posam_pkg::OP_ADD, posam_pkg::NAR, posam_pkg::ZERO);
    queue_op(posam_pkg::OP_MUL, posam_pkg::ZERO, posam_pkg::NAR);
    queue_op(posam_pkg::OP_ADD, posam_pkg::ZERO, 32'h1234_5678);
    queue_op(posam_pkg::OP_ADD, 32'h8765_4321, posam_pkg::ZERO);
    queue_op(posam_pkg::OP_MUL, posam_pkg::ZERO, 32'h1234_5678);
    queue_op(posam_pkg::OP_ADD, 32'h4000_0000, 32'hc000_0000);
    queue_op(posam_pkg::OP_ADD, 32'h1357_9bdf, -32'h1357_9bdf);
    queue_op(posam_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_op(posam_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_op(posam_pkg::OP_MUL, 32'h8000_0001, 32'h7fff_ffff);
    queue_op(posam_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0001);
    queue_op(posam_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
    queue_op(posam_pkg::OP_ADD, 32'h0000_0001, 32'hffff_ffff);
    queue_op(posam_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    queue_op(posam_pkg::OP_MUL, 32'h0000_0003, 32'h7fff_fffe);
    queue_op(posam_pkg::OP_ADD, 32'h0000_0002, 32'h0000_0003);
    queue_op(posam_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    queue_op(posam_pkg::OP_ADD, 32'h4000_0001, 32'hbfff_ffff);
    queue_op(posam_pkg::OP_MUL, 32'h5555_5555, 32'haaaa_aaab);
    queue_op(posam_pkg::OP_ADD, 32'h3fff_ffff, 32'h0000_0007);
    for (int i = 0; i < 530; i++) begin
      a = random_posit();
      // some near-cancelling sums
      if ($urandom_range(0, 7) == 0)
        queue_op(posam_pkg::OP_ADD, a, -(a + $urandom_range(0, 3)));
      else
        queue_op(posam_pkg::op_t'($urandom_range(0, 1)), a, random_posit());
      if (i == 260) begin
        while (pending_ops.size() != 0) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // sender: bursts and gaps
  always @(posedge clk) begin
    req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid && in_ready)
        expected_results.push_back(
          posit_result('{posam_pkg::op_t'(operation), operand_a, operand_b}));
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (!hold_off && pending_ops.size() != 0 && (burst_left > 0)) begin
        r = pending_ops.pop_front();
        in_valid <= 1'b1;
        operation <= r.op;
        operand_a <= r.a;
        operand_b <= r.b;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic [31:0] want;
    cycles++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, result);
            errors++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 97;
      out_ready <= (stall_phase > 60) ? 1'b1 :
                   (stall_phase > 30) ? ($urandom_range(0, 3) != 0) :
                                        ($urandom_range(0, 1) != 0);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && pending_ops.size() == 0 && !in_valid)) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("** posit_add_multiply_unit: PASSED **");
    else
      $display("** posit_add_multiply_unit: FAILED **");
    $finish;
  end

  initial begin
    wait (cycles >= 200000);
    $display("** posit_add_multiply_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== posit_add_multiply_unit.f =====
sv/posam_pkg.sv
sv/posit_add_multiply_unit.sv
tb/testbench.sv
